// ----- rtl/ecs_pkg.sv -----
// Elevator call scheduler package: sizing constants and item/result types.
// No dependencies; used by elevator_call_scheduler_core.
package ecs_pkg;

	localparam int FLOORS          = 4;
	localparam int STEPS_PER_FLOOR = 3;

	localparam int BTN_W   = 4;
	localparam int LAMP_W  = 10;
	localparam int OUT_POS_W = 4;

	localparam int CALL_W  = (FLOORS < BTN_W) ? FLOORS : BTN_W;
	localparam int MAX_POS = (FLOORS - 1) * STEPS_PER_FLOOR;
	localparam int POS_W   = (MAX_POS < 2) ? 1 : $clog2(MAX_POS + 1);
	localparam int FL_W    = $clog2(FLOORS + 1);
	localparam int OFS_W   = (STEPS_PER_FLOOR < 2) ? 1 : $clog2(STEPS_PER_FLOOR);

	typedef struct packed {
		logic [BTN_W-1:0] button_levels;
		logic             move_tick;
	} item_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] cabin_position;
		logic [BTN_W-1:0]     call_lamps;
		logic [OUT_POS_W-1:0] target_position;
		logic                 heading_up;
		logic [LAMP_W-1:0]    position_lamps;
		logic                 any_call;
	} result_t;

endpackage

// ----- rtl/elevator_call_scheduler_core.sv -----
// Elevator call scheduler: input register, one pass of target search and cabin
// step logic, result register. Depends on ecs_pkg.
// A result is registered from the item in the input register; a held result stalls input.
// Throughput: one item per cycle unless a held result stalls; the pass is a four-bit priority
// search and a one-step position update, closed between the input and result registers.
// Reset: calls, button history, position and direction clear; cabin at floor 0.
module elevator_call_scheduler_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  ecs_pkg::item_t item,
	output logic           result_valid,
	input  logic           result_ready,
	output ecs_pkg::result_t result
);
	import ecs_pkg::*;

	// input stage
	logic  valid_s1;
	item_t item_s1;

	// scheduler state; pos_q is kept as floor_q * steps + ofs_q
	logic [CALL_W-1:0] pend_q;
	logic [CALL_W-1:0] last_q;
	logic [POS_W-1:0]  pos_q;
	logic [FL_W-1:0]   floor_q;
	logic [OFS_W-1:0]  ofs_q;
	logic              up_q;

	logic    adv;
	result_t res_d;

	logic [CALL_W-1:0] btn;
	logic [CALL_W-1:0] pend_tog;
	logic [CALL_W-1:0] pend_d;
	logic              any;
	logic              dn_hit, up_hit, hit;
	logic [FL_W-1:0]   dn_f, up_f, tf;
	logic [POS_W-1:0]  tpos;
	logic [POS_W-1:0]  pos_d;
	logic [FL_W-1:0]   floor_d;
	logic [OFS_W-1:0]  ofs_d;
	logic              up_d;

	assign adv        = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_comb begin
		btn      = item_s1.button_levels[CALL_W-1:0];
		pend_tog = pend_q ^ (btn & ~last_q);
		any      = |pend_tog;

		dn_hit = 1'b0;
		dn_f   = '0;
		for (int i = 0; i < CALL_W; i++) begin
			if (pend_tog[i] && (FL_W'(i) <= floor_q)) begin
				dn_hit = 1'b1;
				dn_f   = FL_W'(i);
			end
		end
		up_hit = 1'b0;
		up_f   = '0;
		for (int i = CALL_W - 1; i >= 0; i--) begin
			if (pend_tog[i] && (FL_W'(i) > floor_q)) begin
				up_hit = 1'b1;
				up_f   = FL_W'(i);
			end
		end

		hit = 1'b1;
		tf  = floor_q;
		if (!any) begin
			tf = floor_q + FL_W'(ofs_q != '0);
		end else if (up_q) begin
			if (up_hit) begin
				tf = up_f;
			end else if (dn_hit) begin
				tf = dn_f;
			end else begin
				hit = 1'b0;
			end
		end else begin
			if (dn_hit) begin
				tf = dn_f;
			end else if (up_hit) begin
				tf = up_f;
			end else begin
				hit = 1'b0;
			end
		end
		tpos = hit ? POS_W'(32'(tf) * STEPS_PER_FLOOR) : pos_q;

		pend_d  = pend_tog;
		pos_d   = pos_q;
		floor_d = floor_q;
		ofs_d   = ofs_q;
		up_d    = up_q;
		if (item_s1.move_tick) begin
			if (pos_q == tpos) begin
				for (int i = 0; i < CALL_W; i++) begin
					if (floor_q == FL_W'(i)) begin
						pend_d[i] = 1'b0;
					end
				end
			end else if (pos_q < tpos) begin
				pos_d = pos_q + POS_W'(1);
				up_d  = 1'b1;
				if (32'(ofs_q) == STEPS_PER_FLOOR - 1) begin
					ofs_d   = '0;
					floor_d = floor_q + FL_W'(1);
				end else begin
					ofs_d = ofs_q + OFS_W'(1);
				end
			end else begin
				pos_d = pos_q - POS_W'(1);
				up_d  = 1'b0;
				if (ofs_q == '0) begin
					ofs_d   = OFS_W'(STEPS_PER_FLOOR - 1);
					floor_d = floor_q - FL_W'(1);
				end else begin
					ofs_d = ofs_q - OFS_W'(1);
				end
			end
		end

		res_d.cabin_position  = OUT_POS_W'(pos_d);
		res_d.call_lamps      = BTN_W'(pend_d);
		res_d.target_position = OUT_POS_W'(tpos);
		res_d.heading_up      = up_d;
		res_d.position_lamps  = (32'(pos_d) < LAMP_W) ? (LAMP_W'(1) << pos_d) : '0;
		res_d.any_call        = any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			pend_q       <= '0;
			last_q       <= '0;
			pos_q        <= '0;
			floor_q      <= '0;
			ofs_q        <= '0;
			up_q         <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				result_valid <= 1'b1;
				pend_q       <= pend_d;
				last_q       <= btn;
				pos_q        <= pos_d;
				floor_q      <= floor_d;
				ofs_q        <= ofs_d;
				up_q         <= up_d;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (adv) begin
			result <= res_d;
		end
	end

`ifndef SYNTH
	a_pos_split: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) == 32'(floor_q) * STEPS_PER_FLOOR + 32'(ofs_q))
		else $error("position and floor/offset disagree");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= MAX_POS && 32'(ofs_q) < STEPS_PER_FLOOR)
		else $error("cabin position out of range");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.move_tick && (pos_q != tpos) |=>
		(pos_q == $past(pos_q) + POS_W'(1)) || (pos_q == $past(pos_q) - POS_W'(1)))
		else $error("cabin moved other than one step");

	a_still: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item_s1.move_tick |=> $stable(pos_q) && $stable(up_q))
		else $error("cabin moved without a tick");

	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0(result.position_lamps))
		else $error("position lamps not one-hot");
`endif

endmodule
